// ===== rtl/core/rpap_pkg.sv =====
// ----------------------------------------------------------------------------
// rpap_pkg: shared constants, types and functions for point rotation
// Widths, the CORDIC arctangent table, stage payload types and step logic.
// ----------------------------------------------------------------------------
package rpap_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int ANGLE_WIDTH     = 16;

   localparam int TRIG_WIDTH      = 32;   // Q1.30 cos/sin; CORDIC angle at 2^32 units per turn
   localparam int TRIG_FRAC       = 30;
   localparam int CORDIC_STEPS    = 30;
   localparam int STEPS_PER_STAGE = 5;
   localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int PROD_WIDTH = DIFF_WIDTH + TRIG_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam int RND_WIDTH  = SUM_WIDTH - TRIG_FRAC;
   localparam int EXT_WIDTH  = RND_WIDTH + 1;

   // input reg, cordic stages, multiply, round, output reg
   localparam int NUM_STAGES = CORDIC_STAGES + 4;

   localparam int REQ_DATA_WIDTH = ((4 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] px;
      logic signed [COORD_WIDTH-1:0] py;
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
      logic        [ANGLE_WIDTH-1:0] angle;
   } in_stage_type;

   typedef struct packed {
      logic signed [TRIG_WIDTH-1:0]  x;
      logic signed [TRIG_WIDTH-1:0]  y;
      logic signed [TRIG_WIDTH-1:0]  z;
      logic        [1:0]             quad;
      logic signed [DIFF_WIDTH-1:0]  dx;
      logic signed [DIFF_WIDTH-1:0]  dy;
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
   } cordic_stage_type;

   typedef struct packed {
      logic signed [PROD_WIDTH-1:0]  p_xc;
      logic signed [PROD_WIDTH-1:0]  p_ys;
      logic signed [PROD_WIDTH-1:0]  p_xs;
      logic signed [PROD_WIDTH-1:0]  p_yc;
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
   } mul_stage_type;

   typedef struct packed {
      logic signed [RND_WIDTH-1:0]   rx;
      logic signed [RND_WIDTH-1:0]   ry;
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
   } rnd_stage_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rx;
      logic signed [COORD_WIDTH-1:0] ry;
      logic                          clip;
   } out_stage_type;

   function automatic logic signed [TRIG_WIDTH-1:0] atan_entry(int i);
      logic signed [TRIG_WIDTH-1:0] v;
      case (i)
         0:  v = 32'sd536870912;
         1:  v = 32'sd316933406;
         2:  v = 32'sd167458907;
         3:  v = 32'sd85004756;
         4:  v = 32'sd42667331;
         5:  v = 32'sd21354465;
         6:  v = 32'sd10679838;
         7:  v = 32'sd5340245;
         8:  v = 32'sd2670163;
         9:  v = 32'sd1335087;
         10: v = 32'sd667544;
         11: v = 32'sd333772;
         12: v = 32'sd166886;
         13: v = 32'sd83443;
         14: v = 32'sd41722;
         15: v = 32'sd20861;
         16: v = 32'sd10430;
         17: v = 32'sd5215;
         18: v = 32'sd2608;
         19: v = 32'sd1304;
         20: v = 32'sd652;
         21: v = 32'sd326;
         22: v = 32'sd163;
         23: v = 32'sd81;
         24: v = 32'sd41;
         25: v = 32'sd20;
         26: v = 32'sd10;
         27: v = 32'sd5;
         28: v = 32'sd3;
         29: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // STEPS_PER_STAGE rotation-mode micro-rotations starting at step 'first'
   function automatic cordic_stage_type cordic_steps(cordic_stage_type s, int first);
      cordic_stage_type r;
      logic signed [TRIG_WIDTH-1:0] x;
      logic signed [TRIG_WIDTH-1:0] y;
      logic signed [TRIG_WIDTH-1:0] z;
      logic signed [TRIG_WIDTH-1:0] xs;
      logic signed [TRIG_WIDTH-1:0] ys;
      r = s;
      x = s.x;
      y = s.y;
      z = s.z;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         xs = x >>> (first + j);
         ys = y >>> (first + j);
         if (!z[TRIG_WIDTH-1]) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_entry(first + j);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_entry(first + j);
         end
      end
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

endpackage

// ===== rtl/core/rotate_point_about_pivot.sv =====
// ----------------------------------------------------------------------------
// rotate_point_about_pivot: rotate a Q16.16 point about a pivot
// Pipelined CORDIC sine/cosine, exact products, round and saturate.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word carries point, pivot and a binary turn angle
//   (65536 units per turn, counter-clockwise). rsp channel: one word per
//   request with the rotated point; rsp_tuser is set when a coordinate
//   was saturated to the signed coordinate range.
//   A request reaches rsp_tvalid through the input register, 6 CORDIC
//   stages of 5 steps, multiply, round and output register. Throughput: one
//   word per cycle while the receiver keeps rsp_tready high, set by the
//   10-stage pipeline that takes a new word each cycle.
//   Each stage moves on when the next one is empty or moving, so bubbles
//   close up; when the receiver stalls, words pile up behind the output
//   register and req_tready drops only once every stage is full.
//   Reset clears all stage valid bits; no words are in flight after it.
// ----------------------------------------------------------------------------
module rotate_point_about_pivot (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // point_x, point_y, pivot_x, pivot_y, turn_angle
   input  logic [rpap_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rotated_x, rotated_y
   output logic [rpap_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // clipped
   output logic                                rsp_tuser
);

   localparam int CW  = rpap_pkg::COORD_WIDTH;
   localparam int AW  = rpap_pkg::ANGLE_WIDTH;
   localparam int TW  = rpap_pkg::TRIG_WIDTH;
   localparam int DW  = rpap_pkg::DIFF_WIDTH;
   localparam int SW  = rpap_pkg::SUM_WIDTH;
   localparam int EW  = rpap_pkg::EXT_WIDTH;
   localparam int TF  = rpap_pkg::TRIG_FRAC;
   localparam int NS  = rpap_pkg::NUM_STAGES;
   localparam int NC  = rpap_pkg::CORDIC_STAGES;

   localparam logic signed [SW-1:0] ROUND_HALF =
      {{(SW - TF){1'b0}}, 1'b1, {(TF - 1){1'b0}}};

   logic [NS-1:0] vld_ff, vld_in;
   logic [NS:0]   stage_ready;

   rpap_pkg::in_stage_type     in_ff, in_in;
   rpap_pkg::cordic_stage_type cor_ff [NC];
   rpap_pkg::cordic_stage_type cor_in [NC];
   rpap_pkg::cordic_stage_type cor_init;
   rpap_pkg::mul_stage_type    mul_ff, mul_in;
   rpap_pkg::rnd_stage_type    rnd_ff, rnd_in;
   rpap_pkg::out_stage_type    out_ff, out_in;

   logic signed [AW-3:0] resid;
   logic [AW-1:0]        angle_sum;
   logic signed [TW-1:0] cos_v, sin_v;
   logic signed [SW-1:0] sum_x, sum_y;
   logic signed [EW-1:0] ext_x, ext_y;
   logic                 clip_x, clip_y;

   function automatic logic signed [CW-1:0] saturate(logic signed [EW-1:0] v, output logic clip);
      logic [EW-CW:0] top;
      top  = v[EW-1:CW-1];
      clip = !((&top) || !(|top));
      return clip ? {v[EW-1], {(CW-1){~v[EW-1]}}} : v[CW-1:0];
   endfunction

   // handshake: a stage takes a word when empty or when its word moves on
   always_comb begin
      stage_ready[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         stage_ready[k] = !vld_ff[k] || stage_ready[k+1];
      end
      vld_in[0] = stage_ready[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = stage_ready[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = rpap_pkg::RSP_DATA_WIDTH'({out_ff.ry, out_ff.rx});
   assign rsp_tuser  = out_ff.clip;

   always_comb begin
      in_in.px    = req_tdata[CW-1:0];
      in_in.py    = req_tdata[2*CW-1:CW];
      in_in.qx    = req_tdata[3*CW-1:2*CW];
      in_in.qy    = req_tdata[4*CW-1:3*CW];
      in_in.angle = req_tdata[4*CW+AW-1:4*CW];
   end

   // quadrant split and residual angle scaled to 2^32 units per turn
   always_comb begin
      angle_sum     = in_ff.angle + AW'(1 << (AW - 3));
      resid         = {~angle_sum[AW-3], angle_sum[AW-4:0]};
      cor_init.x    = rpap_pkg::CORDIC_GAIN;
      cor_init.y    = '0;
      cor_init.z    = TW'(resid) <<< (TW - AW);
      cor_init.quad = angle_sum[AW-1:AW-2];
      cor_init.dx   = DW'(in_ff.px) - DW'(in_ff.qx);
      cor_init.dy   = DW'(in_ff.py) - DW'(in_ff.qy);
      cor_init.qx   = in_ff.qx;
      cor_init.qy   = in_ff.qy;
   end

   for (genvar k = 0; k < NC; k++) begin : g_cordic
      if (k == 0) begin : g_first
         assign cor_in[k] = rpap_pkg::cordic_steps(cor_init, 0);
      end else begin : g_next
         assign cor_in[k] = rpap_pkg::cordic_steps(cor_ff[k-1],
                                                   k * rpap_pkg::STEPS_PER_STAGE);
      end
   end

   always_comb begin
      case (cor_ff[NC-1].quad)
         rpap_pkg::QUAD_0: begin
            cos_v = cor_ff[NC-1].x;
            sin_v = cor_ff[NC-1].y;
         end
         rpap_pkg::QUAD_1: begin
            cos_v = -cor_ff[NC-1].y;
            sin_v = cor_ff[NC-1].x;
         end
         rpap_pkg::QUAD_2: begin
            cos_v = -cor_ff[NC-1].x;
            sin_v = -cor_ff[NC-1].y;
         end
         rpap_pkg::QUAD_3: begin
            cos_v = cor_ff[NC-1].y;
            sin_v = -cor_ff[NC-1].x;
         end
         default: begin
            cos_v = cor_ff[NC-1].x;
            sin_v = cor_ff[NC-1].y;
         end
      endcase
      mul_in.p_xc = cor_ff[NC-1].dx * cos_v;
      mul_in.p_ys = cor_ff[NC-1].dy * sin_v;
      mul_in.p_xs = cor_ff[NC-1].dx * sin_v;
      mul_in.p_yc = cor_ff[NC-1].dy * cos_v;
      mul_in.qx   = cor_ff[NC-1].qx;
      mul_in.qy   = cor_ff[NC-1].qy;
   end

   // round to nearest, ties up
   always_comb begin
      sum_x     = SW'(mul_ff.p_xc) - SW'(mul_ff.p_ys) + ROUND_HALF;
      sum_y     = SW'(mul_ff.p_xs) + SW'(mul_ff.p_yc) + ROUND_HALF;
      rnd_in.rx = sum_x[SW-1:TF];
      rnd_in.ry = sum_y[SW-1:TF];
      rnd_in.qx = mul_ff.qx;
      rnd_in.qy = mul_ff.qy;
   end

   always_comb begin
      ext_x       = EW'(rnd_ff.rx) + EW'(rnd_ff.qx);
      ext_y       = EW'(rnd_ff.ry) + EW'(rnd_ff.qy);
      out_in.rx   = saturate(ext_x, clip_x);
      out_in.ry   = saturate(ext_y, clip_y);
      out_in.clip = clip_x || clip_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         in_ff <= in_in;
      end
      for (int k = 0; k < NC; k++) begin
         if (stage_ready[k+1]) begin
            cor_ff[k] <= cor_in[k];
         end
      end
      if (stage_ready[NC+1]) begin
         mul_ff <= mul_in;
      end
      if (stage_ready[NC+2]) begin
         rnd_ff <= rnd_in;
      end
      if (stage_ready[NC+3]) begin
         out_ff <= out_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (out_ff.rx == {1'b0, {(CW-1){1'b1}}} || out_ff.rx == {1'b1, {(CW-1){1'b0}}} ||
          out_ff.ry == {1'b0, {(CW-1){1'b1}}} || out_ff.ry == {1'b1, {(CW-1){1'b0}}}))
      else $error("clip flag without a saturated coordinate");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NS-1] && !rsp_tready && vld_ff[NS-2]) |=> vld_ff[NS-2])
      else $error("word lost behind stalled output");

   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rotate_point_about_pivot
// Streams points, pivots and angles through the block under random bursts and
// receiver stalls, predicts each rotated word with a CORDIC model of its own
// and checks every response field in order.
// ----------------------------------------------------------------------------

localparam int     CW           = rpap_pkg::COORD_WIDTH;
localparam int     AW           = rpap_pkg::ANGLE_WIDTH;
localparam int     ROT_STEPS    = 30;
localparam longint CORDIC_K     = 64'sd652032874;
localparam int     STALL_LIMIT  = 4000;
localparam int     DRAIN_CYCLES = 30;
localparam int     HOLD_CYCLES  = 400;
localparam int     NUM_RANDOM   = 1500;

typedef struct {
   logic signed [CW-1:0] px;
   logic signed [CW-1:0] py;
   logic signed [CW-1:0] qx;
   logic signed [CW-1:0] qy;
   logic        [AW-1:0] ang;
} point_job_type;

typedef struct {
   logic signed [CW-1:0] rx;
   logic signed [CW-1:0] ry;
   logic                 clip;
} rotated_type;

typedef enum {RX_ALWAYS, RX_HALF, RX_CADENCE, RX_SPARSE} rx_mode_type;

class rotation_scoreboard;
   rotated_type rotated_points[$];
   int          mismatches;
   longint      arctan_q30[ROT_STEPS];

   function new();
      mismatches = 0;
      arctan_q30 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                     10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                     83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                     81, 41, 20, 10, 5, 3, 1};
   endfunction

   function rotated_type rotate_about_pivot(point_job_type j);
      rotated_type        o;
      longint             eighth, quarter, a, x, y, z, xs, ys, c, s;
      logic [1:0]         quad;
      logic signed [95:0] dx, dy, cw, sw, rx, ry, lim_hi, lim_lo;
      eighth  = longint'(1) << (AW - 3);
      quarter = eighth << 1;
      a       = longint'(j.ang) + eighth;
      quad    = 2'((a >> (AW - 2)) & 3);
      z       = ((a & (quarter - 1)) - eighth) * (longint'(1) << (32 - AW));
      x       = CORDIC_K;
      y       = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_q30[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_q30[i];
         end
      end
      case (quad)
         rpap_pkg::QUAD_0: begin c = x;  s = y;  end
         rpap_pkg::QUAD_1: begin c = -y; s = x;  end
         rpap_pkg::QUAD_2: begin c = -x; s = -y; end
         default:          begin c = y;  s = -x; end
      endcase
      cw = c;
      sw = s;
      dx = j.px - j.qx;
      dy = j.py - j.qy;
      // round half up at the Q1.30 point
      rx = ((dx * cw - dy * sw + (96'sd1 <<< 29)) >>> 30) + j.qx;
      ry = ((dx * sw + dy * cw + (96'sd1 <<< 29)) >>> 30) + j.qy;
      lim_hi = (96'sd1 <<< (CW - 1)) - 96'sd1;
      lim_lo = -lim_hi - 96'sd1;
      o.clip = 1'b0;
      if (rx > lim_hi) begin
         rx = lim_hi;
         o.clip = 1'b1;
      end else if (rx < lim_lo) begin
         rx = lim_lo;
         o.clip = 1'b1;
      end
      if (ry > lim_hi) begin
         ry = lim_hi;
         o.clip = 1'b1;
      end else if (ry < lim_lo) begin
         ry = lim_lo;
         o.clip = 1'b1;
      end
      o.rx = rx[CW-1:0];
      o.ry = ry[CW-1:0];
      return o;
   endfunction

   function int pending();
      return rotated_points.size();
   endfunction

   function void note_input(point_job_type j);
      rotated_points.push_back(rotate_about_pivot(j));
   endfunction

   task report(string what, longint got_v, longint want_v);
      $display("mismatch %s: got %0d expected %0d", what, got_v, want_v);
      mismatches++;
   endtask

   task check_result(rotated_type got);
      rotated_type want;
      if (rotated_points.size() == 0) begin
         report("unexpected word, rotated_x", got.rx, 0);
         return;
      end
      want = rotated_points.pop_front();
      if (got.rx !== want.rx) report("rotated_x", got.rx, want.rx);
      if (got.ry !== want.ry) report("rotated_y", got.ry, want.ry);
      if (got.clip !== want.clip) report("clipped", got.clip, want.clip);
   endtask
endclass

module testbench;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [rpap_pkg::REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [rpap_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                                rsp_tuser;

   rotation_scoreboard sb = new();
   int                 idle_cycles = 0;
   int                 holdoff_asks = 0;
   int                 holdoff_seen = 0;

   rotate_point_about_pivot u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic point_job_type job(int px, int py, int qx, int qy, int ang);
      point_job_type j;
      j.px  = px;
      j.py  = py;
      j.qx  = qx;
      j.qy  = qy;
      j.ang = AW'(ang);
      return j;
   endfunction

   task automatic send_job(point_job_type j);
      req_tvalid <= 1'b1;
      req_tdata  <= {j.ang, j.qy, j.qx, j.py, j.px};
      do @(posedge clock); while (!req_tready);
   endtask

   // monitor: both handshakes plus the idle count for the watchdog
   always @(posedge clock) begin
      point_job_type j;
      rotated_type   r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            j.px  = req_tdata[CW-1:0];
            j.py  = req_tdata[2*CW-1:CW];
            j.qx  = req_tdata[3*CW-1:2*CW];
            j.qy  = req_tdata[4*CW-1:3*CW];
            j.ang = req_tdata[4*CW+AW-1:4*CW];
            sb.note_input(j);
         end
         if (rsp_tvalid && rsp_tready) begin
            r.rx   = rsp_tdata[CW-1:0];
            r.ry   = rsp_tdata[2*CW-1:CW];
            r.clip = rsp_tuser;
            sb.check_result(r);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // receiver: stall pattern drawn at random from four modes; long hold-off on request
   initial begin
      rx_mode_type mode;
      int          tick;
      mode = RX_ALWAYS;
      tick = 0;
      forever begin
         @(posedge clock);
         if (holdoff_seen != holdoff_asks) begin
            holdoff_seen++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            tick++;
            if (tick % 50 == 0) mode = rx_mode_type'($urandom_range(0, 3));
            case (mode)
               RX_ALWAYS:  rsp_tready <= 1'b1;
               RX_HALF:    rsp_tready <= 1'($urandom_range(0, 1));
               RX_CADENCE: rsp_tready <= (tick % 5 != 0);
               default:    rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      point_job_type j;
      int            burst_left, gap, sel, no_gap_until;
      burst_left   = 0;
      no_gap_until = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, every quadrant and octant boundary, range extremes
      send_job(job(0, 0, 0, 0, 0));
      send_job(job(1 << 16, 0, 0, 0, 16384));
      for (int k = 0; k < 8; k++)
         send_job(job(100 << 16, 50 << 16, 3 << 16, -(7 << 16), k * 8192));
      send_job(job(100 << 16, 50 << 16, 3 << 16, -(7 << 16), 8191));
      send_job(job(100 << 16, 50 << 16, 3 << 16, -(7 << 16), 65535));
      send_job(job(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0));
      send_job(job(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32768));
      send_job(job(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16384));
      send_job(job(32'h7fffffff, 32'h80000000, 0, 0, 8192));
      send_job(job(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 12345));
      send_job(job(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 65535));
      send_job(job(32'h7fffffff, 32'h7fffffff, 0, 0, 0));
      send_job(job(-1, -1, 1, 1, 49151));

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 300) begin
            holdoff_asks++;
            no_gap_until = n + 60;
         end
         if (n == 900) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end else if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0 || n < no_gap_until) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         sel = $urandom_range(0, 9);
         if (sel <= 3) begin
            j.qx = $urandom_range(0, 2**30) - 2**29;
            j.qy = $urandom_range(0, 2**30) - 2**29;
            j.px = j.qx + $urandom_range(0, 2**21) - 2**20;
            j.py = j.qy + $urandom_range(0, 2**21) - 2**20;
         end else if (sel <= 5) begin
            j.px = $urandom;
            j.py = $urandom;
            j.qx = $urandom;
            j.qy = $urandom;
         end else if (sel == 6) begin
            // pivot near a range edge, so rotations often saturate
            j.qx = ($urandom_range(0, 1) ? 32'h7f000000 : 32'h80000000) + $urandom_range(0, 2**24);
            j.qy = ($urandom_range(0, 1) ? 32'h7f000000 : 32'h80000000) + $urandom_range(0, 2**24);
            j.px = j.qx + $urandom_range(0, 2**25) - 2**24;
            j.py = j.qy + $urandom_range(0, 2**25) - 2**24;
         end else begin
            j.px = $urandom_range(0, 2**29) - 2**28;
            j.py = $urandom_range(0, 2**29) - 2**28;
            j.qx = $urandom_range(0, 2**29) - 2**28;
            j.qy = $urandom_range(0, 2**29) - 2**28;
         end
         if ($urandom_range(0, 3) == 0)
            j.ang = AW'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
         else
            j.ang = AW'($urandom);
         send_job(j);
         burst_left--;
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
